@@ src/ble_pkg.sv @@
// Shared types and codes for the bounded list engine.
package ble_pkg;

   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 2;

   localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_SORTED_INS = 3'd2;
   localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd4;
   localparam logic [OP_BITS-1:0] OP_DELETE     = 3'd5;
   localparam logic [OP_BITS-1:0] OP_UNUSED_LO  = 3'd6;
   localparam logic [OP_BITS-1:0] OP_UNUSED_HI  = 3'd7;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_WALK  = 4'b0010,
      S_LINK2 = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

endpackage

@@ src/bounded_list_engine_top.sv @@
// Bounded ordered list engine: linked slot store walked by a one-read-per-cycle sequencer.
// Pushes and empty/full/unused requests go through the done state to the result register;
// pop front passes walk and done; sorted insert, pop back and delete walk one node per
// cycle over the slot store read port before done. One request is in flight at a time.
// Reset (synchronous, active high) empties the list; slot stores need no clearing.
module bounded_list_engine_top #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   localparam int SLOT_BITS  = $clog2(CAPACITY),
   localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ble_pkg::OP_BITS-1:0]         req_operation,
   input  logic signed [VALUE_BITS-1:0]        req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [VALUE_BITS-1:0]        rsp_removed_value,
   output logic [ble_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [COUNT_BITS-1:0]               rsp_length
);
   import ble_pkg::*;

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);
   localparam logic [COUNT_BITS-1:0] ONE_COUNT  = COUNT_BITS'(1);

   state_type state_ff, state_in;
   logic [SLOT_BITS-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] free_top_ff, free_top_in, fresh_ff, fresh_in;
   logic [OP_BITS-1:0]    op_ff, op_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in, cur_ff, cur_in, prev_ff, prev_in, k_ff, k_in;
   logic signed [VALUE_BITS-1:0] res_removed_ff, res_removed_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS-1:0] rsp_removed_ff, rsp_removed_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0] rsp_length_ff, rsp_length_in;

   logic signed [VALUE_BITS-1:0] elem_mem [CAPACITY];
   logic [SLOT_BITS-1:0] link_mem [CAPACITY];
   logic [SLOT_BITS-1:0] free_mem [CAPACITY];
   logic signed [VALUE_BITS-1:0] elem_q;
   logic [SLOT_BITS-1:0] link_q, free_q;

   logic [SLOT_BITS-1:0] rd_addr, new_slot;
   logic elem_we, link_we, free_push, slot_alloc;
   logic [SLOT_BITS-1:0] elem_wa, link_wa, link_wd;
   logic signed [VALUE_BITS-1:0] elem_wd;
   logic [COUNT_BITS-1:0] free_rd_idx;
   logic last_node;

   assign free_rd_idx = free_top_ff - ONE_COUNT;
   assign new_slot = (free_top_ff != '0) ? free_q : fresh_ff[SLOT_BITS-1:0];
   assign last_node = (COUNT_BITS'(k_ff) == (count_ff - ONE_COUNT));

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_wa] <= elem_wd;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (free_push) begin
         free_mem[free_top_ff[SLOT_BITS-1:0]] <= cur_ff;
      end
      elem_q <= elem_mem[rd_addr];
      link_q <= link_mem[rd_addr];
      free_q <= free_mem[free_rd_idx[SLOT_BITS-1:0]];
   end

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      value_in       = value_ff;
      slot_in        = slot_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      k_in           = k_ff;
      res_removed_in = res_removed_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_length_in  = rsp_length_ff;
      rd_addr        = cur_ff;
      elem_we        = 1'b0;
      elem_wa        = new_slot;
      elem_wd        = req_value;
      link_we        = 1'b0;
      link_wa        = new_slot;
      link_wd        = head_ff;
      free_push      = 1'b0;
      slot_alloc     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            rd_addr = head_ff;
            if (req_valid) begin
               op_in          = req_operation;
               value_in       = req_value;
               slot_in        = new_slot;
               cur_in         = head_ff;
               prev_in        = head_ff;
               k_in           = '0;
               res_removed_in = '0;
               res_status_in  = ST_OK;
               state_in       = S_DONE;
               if (req_operation == OP_PUSH_FRONT || req_operation == OP_PUSH_BACK ||
                   req_operation == OP_SORTED_INS) begin
                  if (count_ff == FULL_COUNT) begin
                     res_status_in = ST_FULL;
                  end else if (req_operation == OP_PUSH_BACK) begin
                     elem_we    = 1'b1;
                     slot_alloc = 1'b1;
                     count_in   = count_ff + ONE_COUNT;
                     tail_in    = new_slot;
                     if (count_ff == '0) begin
                        head_in = new_slot;
                     end else begin
                        link_we = 1'b1;
                        link_wa = tail_ff;
                        link_wd = new_slot;
                     end
                  end else if (req_operation == OP_PUSH_FRONT || count_ff == '0) begin
                     elem_we    = 1'b1;
                     link_we    = 1'b1;
                     slot_alloc = 1'b1;
                     count_in   = count_ff + ONE_COUNT;
                     head_in    = new_slot;
                     if (count_ff == '0) begin
                        tail_in = new_slot;
                     end
                  end else begin
                     state_in = S_WALK;
                  end
               end else if (req_operation == OP_POP_FRONT || req_operation == OP_POP_BACK ||
                            req_operation == OP_DELETE) begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_WALK: begin
            rd_addr = link_q;
            elem_wa = slot_ff;
            elem_wd = value_ff;
            case (op_ff)
               OP_SORTED_INS: begin
                  if (value_ff < elem_q) begin
                     elem_we    = 1'b1;
                     link_we    = 1'b1;
                     link_wa    = slot_ff;
                     link_wd    = cur_ff;
                     slot_alloc = 1'b1;
                     count_in   = count_ff + ONE_COUNT;
                     if (k_ff == '0) begin
                        head_in  = slot_ff;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_LINK2;
                     end
                  end else if (last_node) begin
                     elem_we    = 1'b1;
                     link_we    = 1'b1;
                     link_wa    = cur_ff;
                     link_wd    = slot_ff;
                     slot_alloc = 1'b1;
                     count_in   = count_ff + ONE_COUNT;
                     tail_in    = slot_ff;
                     state_in   = S_DONE;
                  end else begin
                     cur_in  = link_q;
                     prev_in = cur_ff;
                     k_in    = k_ff + SLOT_BITS'(1);
                  end
               end
               OP_POP_FRONT: begin
                  res_removed_in = elem_q;
                  head_in        = link_q;
                  free_push      = 1'b1;
                  count_in       = count_ff - ONE_COUNT;
                  state_in       = S_DONE;
               end
               OP_POP_BACK: begin
                  if (last_node) begin
                     res_removed_in = elem_q;
                     tail_in        = prev_ff;
                     free_push      = 1'b1;
                     count_in       = count_ff - ONE_COUNT;
                     state_in       = S_DONE;
                  end else begin
                     cur_in  = link_q;
                     prev_in = cur_ff;
                     k_in    = k_ff + SLOT_BITS'(1);
                  end
               end
               OP_DELETE: begin
                  if (elem_q == value_ff) begin
                     res_removed_in = elem_q;
                     free_push      = 1'b1;
                     count_in       = count_ff - ONE_COUNT;
                     state_in       = S_DONE;
                     if (k_ff == '0) begin
                        head_in = link_q;
                     end else begin
                        link_we = 1'b1;
                        link_wa = prev_ff;
                        link_wd = link_q;
                        if (last_node) begin
                           tail_in = prev_ff;
                        end
                     end
                  end else if (last_node) begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end else begin
                     cur_in  = link_q;
                     prev_in = cur_ff;
                     k_in    = k_ff + SLOT_BITS'(1);
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_LINK2: begin
            link_we  = 1'b1;
            link_wa  = prev_ff;
            link_wd  = slot_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_removed_in = res_removed_ff;
               rsp_status_in  = res_status_ff;
               rsp_length_in  = count_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      free_top_in = free_top_ff;
      fresh_in    = fresh_ff;
      if (free_push) begin
         free_top_in = free_top_ff + ONE_COUNT;
      end else if (slot_alloc) begin
         if (free_top_ff != '0) begin
            free_top_in = free_top_ff - ONE_COUNT;
         end else begin
            fresh_in = fresh_ff + ONE_COUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         free_top_ff  <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_top_ff  <= free_top_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      value_ff       <= value_in;
      slot_ff        <= slot_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      k_ff           <= k_in;
      res_removed_ff <= res_removed_in;
      res_status_ff  <= res_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_length_ff  <= rsp_length_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_length        = rsp_length_ff;

endmodule

@@ tb/ble_checker.sv @@
// Checker for the bounded list engine: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module ble_checker #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [ble_pkg::OP_BITS-1:0]         req_operation,
   input  logic signed [VALUE_BITS-1:0]        req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [VALUE_BITS-1:0]        rsp_removed_value,
   input  logic [ble_pkg::STATUS_BITS-1:0]     rsp_status,
   input  logic [COUNT_BITS-1:0]               rsp_length,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  beat_count
);
   import ble_pkg::*;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] removed;
      logic [STATUS_BITS-1:0]       status;
      logic [COUNT_BITS-1:0]        length;
   } outcome_type;

   // list contents, front at index 0
   logic signed [VALUE_BITS-1:0] list_q[$];
   outcome_type                  outcome_q[$];

   function automatic outcome_type apply_request(logic [OP_BITS-1:0] op,
                                                 logic signed [VALUE_BITS-1:0] v);
      outcome_type o;
      int          pos;
      o = '0;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_SORTED_INS) begin
         if (list_q.size() >= CAPACITY) o.status = ST_FULL;
         else if (op == OP_PUSH_FRONT) list_q.push_front(v);
         else if (op == OP_PUSH_BACK) list_q.push_back(v);
         else begin
            pos = 0;
            while (pos < list_q.size() && !(v < list_q[pos])) pos++;
            list_q.insert(pos, v);
         end
      end else if (op == OP_POP_FRONT || op == OP_POP_BACK || op == OP_DELETE) begin
         if (list_q.size() == 0) o.status = ST_EMPTY;
         else if (op == OP_POP_FRONT) o.removed = list_q.pop_front();
         else if (op == OP_POP_BACK) o.removed = list_q.pop_back();
         else begin
            pos = 0;
            while (pos < list_q.size() && list_q[pos] != v) pos++;
            if (pos == list_q.size()) o.status = ST_NOT_FOUND;
            else begin
               o.removed = list_q[pos];
               list_q.delete(pos);
            end
         end
      end
      o.length = COUNT_BITS'(list_q.size());
      return o;
   endfunction

   assign pending_count = outcome_q.size();

   always @(posedge clock) begin
      outcome_type exp_o;
      int          errs;
      errs = 0;
      if (reset) begin
         list_q.delete();
         outcome_q.delete();
         fail_count <= 0;
         beat_count <= 0;
      end else begin
         if (req_valid && !req_stall) outcome_q.push_back(apply_request(req_operation, req_value));
         if (rsp_valid && !rsp_stall) begin
            beat_count <= beat_count + 1;
            if (outcome_q.size() == 0) begin
               $error("result beat with no request pending");
               errs++;
            end else begin
               exp_o = outcome_q.pop_front();
               if (rsp_removed_value !== exp_o.removed) begin
                  $error("removed_value expected %0d actual %0d", exp_o.removed,
                         rsp_removed_value);
                  errs++;
               end
               if (rsp_status !== exp_o.status) begin
                  $error("status expected %0d actual %0d", exp_o.status, rsp_status);
                  errs++;
               end
               if (rsp_length !== exp_o.length) begin
                  $error("length expected %0d actual %0d", exp_o.length, rsp_length);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

@@ tb/tb_bounded_list_engine_top.sv @@
// Testbench top for the bounded list engine: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_bounded_list_engine_top;
   import ble_pkg::*;

   localparam int CAPACITY   = 16;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int N_RANDOM   = 830;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [OP_BITS-1:0]            req_operation = OP_PUSH_FRONT;
   logic signed [VALUE_BITS-1:0]  req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [VALUE_BITS-1:0]  rsp_removed_value;
   logic [STATUS_BITS-1:0]        rsp_status;
   logic [COUNT_BITS-1:0]         rsp_length;
   int                            fail_count, pending_count, beat_count;
   int                            sent_count = 0;
   int                            pool_size = 4;
   logic signed [VALUE_BITS-1:0]  pool[8];
   bit                            sending_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   bounded_list_engine_top #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) i_dut (.*);

   ble_checker #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS))
      i_checker (.*);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_beat(logic [OP_BITS-1:0] op, logic signed [VALUE_BITS-1:0] v);
      req_operation <= op;
      req_value     <= v;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic idle_gap();
      int n;
      n = gap_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return pool[$urandom_range(0, pool_size - 1)];
      if (r == 6) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      return $urandom();
   endfunction

   // receiver stalls: long stall-free stretches mixed with bursts
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = $urandom_range(0, 3) == 0 ? 0 : gap_length();
         rsp_stall <= n > 0;
         repeat (n > 0 ? n : $urandom_range(1, 40)) @(negedge clock);
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   end

   initial begin
      int               k, r, phase;
      logic [OP_BITS-1:0] op;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // empty list cases
      send_beat(OP_POP_FRONT, 0);
      send_beat(OP_POP_BACK, 0);
      send_beat(OP_DELETE, 5);
      send_beat(OP_UNUSED_LO, 32'shffffffff);
      send_beat(OP_UNUSED_HI, 0);
      // fill past capacity with extremes and duplicates
      send_beat(OP_SORTED_INS, 32'sh7fffffff);
      send_beat(OP_SORTED_INS, 32'sh80000000);
      send_beat(OP_SORTED_INS, 0);
      send_beat(OP_SORTED_INS, 0);
      send_beat(OP_PUSH_FRONT, -1);
      send_beat(OP_PUSH_BACK, 32'sh55555555);
      for (k = 0; k < 11; k++) send_beat(OP_SORTED_INS, k[0] ? 32'shaaaaaaaa : 7);
      send_beat(OP_DELETE, 99);
      send_beat(OP_DELETE, 7);
      send_beat(OP_POP_BACK, 0);
      send_beat(OP_POP_FRONT, 0);
      for (k = 0; k < N_RANDOM; k++) begin
         if (k % 120 == 0) begin
            phase = $urandom_range(0, 2);
            pool_size = phase == 0 ? 2 : (phase == 1 ? 4 : 8);
            for (r = 0; r < 8; r++) pool[r] = $urandom_range(0, 1) ? $urandom() :
                                                $signed($urandom_range(0, 6)) - 3;
         end
         r = $urandom_range(0, 99);
         if (r < 12) op = OP_PUSH_FRONT;
         else if (r < 24) op = OP_PUSH_BACK;
         else if (r < 42) op = OP_SORTED_INS;
         else if (r < 56) op = OP_POP_FRONT;
         else if (r < 70) op = OP_POP_BACK;
         else if (r < 97) op = OP_DELETE;
         else op = $urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
         send_beat(op, pick_value());
         idle_gap();
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      wait (sending_done);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d requests across all six operations plus unused codes;", sent_count);
      $display("checked %0d result beats under random stalls and gaps.", beat_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
